>>> hdl/rmfh_pkg.sv
// rmfh_pkg: shared constants and types for the recursive mutex with FIFO handoff.
// No dependencies; imported by the top level, the port checker and the testbench.
`timescale 1ns / 1ps

package rmfh_pkg;

    // Wait queue size and field widths (fixed by the item format)
    localparam int QUEUE_DEPTH = 16;
    localparam int THREAD_BITS = 8;
    localparam int DEPTH_BITS  = 16;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);
    localparam int STATUS_BITS = 3;

    typedef logic [THREAD_BITS-1:0] tid_t;
    typedef logic [DEPTH_BITS-1:0]  depth_t;
    typedef logic [PTR_BITS-1:0]    ptr_t;
    typedef logic [COUNT_BITS-1:0]  count_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_ACQUIRED = 3'd0,
        ST_QUEUED   = 3'd1,
        ST_LOWERED  = 3'd2,
        ST_FREED    = 3'd3,
        ST_HANDOFF  = 3'd4,
        ST_IGNORED  = 3'd5,
        ST_FULL     = 3'd6
    } status_t;

    typedef enum logic {
        ACT_LOCK   = 1'b0,
        ACT_UNLOCK = 1'b1
    } action_t;

    localparam depth_t DEPTH_MAX = {DEPTH_BITS{1'b1}};
    localparam count_t COUNT_FULL = COUNT_BITS'(QUEUE_DEPTH);
    localparam ptr_t   PTR_LAST   = PTR_BITS'(QUEUE_DEPTH - 1);

endpackage

>>> hdl/recursive_mutex_fifo_handoff.sv
// recursive_mutex_fifo_handoff: recursive mutex, FIFO wait queue, direct handoff.
// Depends on rmfh_pkg.
//
// Usage
// - Input channel (in_valid/in_ready): one item is a lock or unlock request,
//   action (0 lock, 1 unlock) plus the requesting thread_id.
// - Output channel (out_valid/out_ready): exactly one result item per request:
//   status, wake_thread (new owner on handoff, else 0), holder, nesting and
//   waiting_count, all as they stand after the request.
// - Output timing: the result is registered and presented in the cycle after the request is taken.
// - Throughput: one request per cycle unless out_ready stalls. The update of
//   owner, depth and queue is one pass of compares and one increment/decrement.
// - Stall: the result register is the only buffer. in_ready is high while the
//   result register is empty or is being drained in the same cycle, so a
//   stalled receiver holds off the sender without losing or repeating items.
// - Reset (rst_n low, asynchronous): mutex free, queue empty, no result
//   pending. The wait queue storage itself is not cleared; an entry is only
//   ever read after it was written.
// - Overflow: a lock at maximum depth or with a full queue changes nothing and
//   reports ST_FULL; an unlock by a non-owner reports ST_IGNORED.
`timescale 1ns / 1ps

module recursive_mutex_fifo_handoff (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       action,
    input  logic [7:0] thread_id,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic [7:0] wake_thread,
    output logic [7:0] holder,
    output logic [15:0] nesting,
    output logic [4:0] waiting_count
);
    import rmfh_pkg::*;

    // Mutex state
    tid_t   owner_reg,  owner_next;
    depth_t depth_reg,  depth_next;
    ptr_t   head_reg,   head_next;
    ptr_t   tail_reg,   tail_next;
    count_t count_reg,  count_next;
    tid_t   fifo_mem [QUEUE_DEPTH];

    // Result register
    logic    out_valid_reg, out_valid_next;
    status_t status_reg,    status_next;
    tid_t    wake_reg,      wake_next;
    tid_t    holder_reg,    holder_next;
    depth_t  nesting_reg;
    count_t  waiting_reg;

    logic   accept;
    logic   push;
    tid_t   tid;
    logic   locked;
    depth_t depth_dec;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign tid      = tid_t'(thread_id);
    assign locked   = (depth_reg != '0);
    assign depth_dec = depth_reg - depth_t'(1);

    // Single-pass request evaluation
    always_comb
    begin
        owner_next  = owner_reg;
        depth_next  = depth_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        status_next = ST_IGNORED;
        wake_next   = '0;
        push        = 1'b0;

        case (action_t'(action))
            ACT_LOCK:
            begin
                if (!locked || owner_reg == tid)
                begin
                    if (depth_reg == DEPTH_MAX)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        owner_next  = tid;
                        depth_next  = depth_reg + depth_t'(1);
                        status_next = ST_ACQUIRED;
                    end
                end
                else if (count_reg == COUNT_FULL)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    push        = 1'b1;
                    tail_next   = (tail_reg == PTR_LAST) ? '0 : tail_reg + ptr_t'(1);
                    count_next  = count_reg + count_t'(1);
                    status_next = ST_QUEUED;
                end
            end
            ACT_UNLOCK:
            begin
                if (!locked || owner_reg != tid)
                begin
                    status_next = ST_IGNORED;
                end
                else if (depth_dec != '0)
                begin
                    depth_next  = depth_dec;
                    status_next = ST_LOWERED;
                end
                else if (count_reg == '0)
                begin
                    depth_next  = '0;
                    status_next = ST_FREED;
                end
                else
                begin
                    // handoff to queue head at depth one
                    owner_next  = fifo_mem[head_reg];
                    head_next   = (head_reg == PTR_LAST) ? '0 : head_reg + ptr_t'(1);
                    count_next  = count_reg - count_t'(1);
                    depth_next  = depth_t'(1);
                    wake_next   = fifo_mem[head_reg];
                    status_next = ST_HANDOFF;
                end
            end
            default:
            begin
                status_next = ST_IGNORED;
            end
        endcase

        holder_next = (depth_next != '0) ? owner_next : '0;
    end

    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_reg     <= '0;
            depth_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                owner_reg <= owner_next;
                depth_reg <= depth_next;
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
        end
    end

    // Queue storage and result payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept && push)
            fifo_mem[tail_reg] <= tid;
        if (accept)
        begin
            status_reg  <= status_next;
            wake_reg    <= wake_next;
            holder_reg  <= holder_next;
            nesting_reg <= depth_next;
            waiting_reg <= count_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign wake_thread   = 8'(wake_reg);
    assign holder        = 8'(holder_reg);
    assign nesting       = 16'(nesting_reg);
    assign waiting_count = 5'(waiting_reg);

endmodule

>>> hdl/rmfh_checker.sv
// rmfh_checker: port-level assertions for recursive_mutex_fifo_handoff.
// Depends on rmfh_pkg; bound to the top level at the end of this file.
`timescale 1ns / 1ps

module rmfh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [7:0]  wake_thread,
    input logic [7:0]  holder,
    input logic [15:0] nesting
);
    import rmfh_pkg::*;

    // a stalled result stays presented
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped under stall");

    // handoff grants the woken thread at depth one
    a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_HANDOFF |-> nesting == 16'd1 && holder == wake_thread)
        else $error("handoff result inconsistent");

    // wake_thread only names a thread on handoff
    a_wake_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_HANDOFF |-> wake_thread == 8'd0)
        else $error("wake_thread set without handoff");

    // a free mutex reports no holder
    a_free_holder: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && nesting == 16'd0 |-> holder == 8'd0)
        else $error("holder reported while free");

    // a result is produced for every request taken
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no result after request");

endmodule

bind recursive_mutex_fifo_handoff rmfh_checker u_rmfh_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .wake_thread (wake_thread),
    .holder      (holder),
    .nesting     (nesting)
);

>>> test/testbench.sv
// testbench: self-checking bench for recursive_mutex_fifo_handoff.
// Depends on rmfh_pkg and the top level; carries its own model of the mutex and wait queue.
`timescale 1ns / 1ps

module testbench;

    import rmfh_pkg::*;

    // Run limits
    localparam int HOLD_CYCLES    = 200;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no handshake at all
    localparam int SETTLE_CYCLES  = 8;     // allow a margin for stray results
    localparam int PRINT_LIMIT    = 20;
    localparam int NEST_STEPS     = 40;    // extra nesting levels in the deep test
    localparam int RANDOM_ITEMS   = 150;   // items per random phase

    // Expected contents of one result item
    typedef struct {
        status_t st;
        tid_t    wake;
        tid_t    holder;
        depth_t  nest;
        count_t  waiting;
    } mutex_result_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic       action    = ACT_LOCK;
    logic [7:0] thread_id = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] status;
    logic [7:0] wake_thread;
    logic [7:0] holder;
    logic [15:0] nesting;
    logic [4:0] waiting_count;

    // Shadow state of the mutex, updated once per accepted request
    tid_t          lock_owner = '0;
    depth_t        lock_depth = '0;
    tid_t          waiter_queue[$];
    mutex_result_t mutex_results_due[$];

    int idle_pct       = 0;   // chance per cycle that the sender holds back
    int stall_pct      = 0;   // chance per cycle that the receiver stalls
    int hold_seq       = 0;   // bumped by a test to start a long hold-off
    int hold_seen      = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int mismatch_count = 0;

    recursive_mutex_fifo_handoff u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .thread_id     (thread_id),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .wake_thread   (wake_thread),
        .holder        (holder),
        .nesting       (nesting),
        .waiting_count (waiting_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Mutex model: lock grants to a free mutex or the current owner, else
    // the caller joins the wait queue; the owner's last unlock hands the
    // mutex straight to the queue head with depth one.
    // ------------------------------------------------------------------
    function automatic mutex_result_t predict_request(input action_t act, input tid_t tid);
        mutex_result_t r;
        r.st   = ST_IGNORED;
        r.wake = '0;
        if (act == ACT_LOCK)
        begin
            if (lock_depth == '0 || lock_owner == tid)
            begin
                // saturate rather than wrap the nesting count
                if (lock_depth == DEPTH_MAX)
                    r.st = ST_FULL;
                else
                begin
                    lock_owner = tid;
                    lock_depth = lock_depth + depth_t'(1);
                    r.st       = ST_ACQUIRED;
                end
            end
            else if (waiter_queue.size() >= QUEUE_DEPTH)
                r.st = ST_FULL;
            else
            begin
                // no duplicate check: a waiter that locks again is queued twice
                waiter_queue.push_back(tid);
                r.st = ST_QUEUED;
            end
        end
        else if (lock_depth != '0 && lock_owner == tid)
        begin
            lock_depth = lock_depth - depth_t'(1);
            if (lock_depth != '0)
                r.st = ST_LOWERED;
            else if (waiter_queue.size() == 0)
                r.st = ST_FREED;    // owner is kept but reported as 0
            else
            begin
                lock_owner = waiter_queue.pop_front();
                lock_depth = depth_t'(1);
                r.wake     = lock_owner;
                r.st       = ST_HANDOFF;
            end
        end
        r.holder  = (lock_depth != '0) ? lock_owner : '0;
        r.nest    = lock_depth;
        r.waiting = count_t'(waiter_queue.size());
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Result checker. Requests are modelled at the edge that takes them,
    // before results at the same edge are compared, so order is fixed.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        mutex_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                mutex_results_due.push_back(predict_request(action_t'(action), thread_id));
            if (out_valid === 1'b1 && out_ready)
            begin
                if (mutex_results_due.size() == 0)
                    report_mismatch($sformatf("result item with none due, status %0d", status));
                else
                begin
                    want = mutex_results_due.pop_front();
                    if (status !== want.st)
                        report_mismatch($sformatf("status %0d, want %0d", status, want.st));
                    if (wake_thread !== want.wake)
                        report_mismatch($sformatf("wake_thread %0d, want %0d",
                                                  wake_thread, want.wake));
                    if (holder !== want.holder)
                        report_mismatch($sformatf("holder %0d, want %0d", holder, want.holder));
                    if (nesting !== want.nest)
                        report_mismatch($sformatf("nesting %0d, want %0d", nesting, want.nest));
                    if (waiting_count !== want.waiting)
                        report_mismatch($sformatf("waiting_count %0d, want %0d",
                                                  waiting_count, want.waiting));
                end
            end
        end
    end

    // Receiver: random stalls, or a counted hold-off when a test asks for one
    always @(posedge clk)
    begin
        if (hold_seen != hold_seq)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog: too long with no handshake on either channel ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Sender. Valid is dropped only for an idle cycle or a pause for results, so
    // back to back items keep it high without a fall and rise in one step.
    // ------------------------------------------------------------------
    task automatic offer_request(input action_t act, input tid_t tid);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        thread_id <= tid;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
    endtask

    // Sender pause until every result due has come back; the first edge lets
    // the last item taken be logged before the count is looked at
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (mutex_results_due.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Nesting, ignored unlocks, queueing with a repeated waiter, chained
    // handoffs, release to free and the stale owner after release.
    task automatic test_directed_locking();
        idle_pct  = 0;
        stall_pct = 0;
        offer_request(ACT_UNLOCK, 8'h00);   // unlock while free
        offer_request(ACT_LOCK,   8'hFF);
        offer_request(ACT_LOCK,   8'hFF);   // recursive lock
        offer_request(ACT_UNLOCK, 8'h00);   // non-owner unlock
        offer_request(ACT_LOCK,   8'h00);
        offer_request(ACT_LOCK,   8'hAA);
        offer_request(ACT_LOCK,   8'h00);   // same waiter queued twice
        offer_request(ACT_UNLOCK, 8'hFF);   // depth lowered
        offer_request(ACT_UNLOCK, 8'hFF);   // handoff to 0x00
        offer_request(ACT_UNLOCK, 8'hAA);   // not the owner yet
        offer_request(ACT_UNLOCK, 8'h00);   // handoff to 0xAA
        offer_request(ACT_UNLOCK, 8'hAA);   // handoff to 0x00 again
        offer_request(ACT_UNLOCK, 8'h00);   // released free
        offer_request(ACT_UNLOCK, 8'h00);   // stale owner, ignored
        offer_request(ACT_LOCK,   8'h55);
        offer_request(ACT_LOCK,   8'h00);
        offer_request(ACT_UNLOCK, 8'h55);   // handoff to 0x00
        offer_request(ACT_UNLOCK, 8'h00);   // free again
    endtask

    // Fill the queue with pointers off zero so they wrap, reject one more,
    // show the owner still nests while full, then drain in order.
    task automatic test_queue_full();
        idle_pct  = 0;
        stall_pct = 0;
        offer_request(ACT_LOCK, 8'h55);
        for (int i = 0; i < QUEUE_DEPTH; i++)
            offer_request(ACT_LOCK, tid_t'(8'h10 + i));
        offer_request(ACT_LOCK, 8'h99);     // queue full
        offer_request(ACT_LOCK, 8'h55);     // owner unaffected by a full queue
        offer_request(ACT_UNLOCK, 8'h55);
        offer_request(ACT_UNLOCK, 8'h55);   // handoff frees one slot
        offer_request(ACT_LOCK, 8'h99);     // now it fits
        for (int i = 1; i < QUEUE_DEPTH; i++)
            offer_request(ACT_UNLOCK, tid_t'(8'h10 + i - 1));
        offer_request(ACT_UNLOCK, tid_t'(8'h10 + QUEUE_DEPTH - 1));
        offer_request(ACT_UNLOCK, 8'h99);   // last waiter releases to free
    endtask

    // Receiver holds off for a long stretch while requests keep coming, so
    // the single result register fills and in_ready drops; then the sender
    // stops until all results are back.
    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_seq  = hold_seq + 1;
        for (int i = 0; i < 12; i++)
            offer_request(action_t'(i[1]), tid_t'(8'h30 + i[1:0]));
        wait_for_results();
        offer_request(ACT_UNLOCK, 8'h30);
        offer_request(ACT_UNLOCK, 8'h31);
    endtask

    // The owner left by the back-pressure test (0x30 at depth two) nests
    // much deeper, another thread queues behind, then the owner unwinds all
    // the way down to a handoff.
    task automatic test_deep_nesting();
        idle_pct  = 0;
        stall_pct = 0;
        wait_for_results();
        for (int i = 0; i < NEST_STEPS; i++)
            offer_request(ACT_LOCK, 8'h30);
        offer_request(ACT_LOCK, 8'h01);
        for (int i = 0; i < NEST_STEPS + 2; i++)
            offer_request(ACT_UNLOCK, 8'h30);
    endtask

    // Mostly requests from a few threads so that nesting, queueing and
    // handoff happen all the time; the rest is fully random noise.
    task automatic run_random_phase(input int items, input int idle, input int stall);
        tid_t pool[4];
        idle_pct  = idle;
        stall_pct = stall;
        foreach (pool[k])
            pool[k] = tid_t'($urandom_range(0, 255));
        for (int i = 0; i < items; i++)
        begin
            if ($urandom_range(0, 99) < 85)
                offer_request(($urandom_range(0, 99) < 55) ? ACT_UNLOCK : ACT_LOCK,
                              pool[$urandom_range(0, 3)]);
            else
                offer_request(action_t'($urandom_range(0, 1)),
                              tid_t'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(RANDOM_ITEMS, 0,  0);
        run_random_phase(RANDOM_ITEMS, 52, 0);
        run_random_phase(RANDOM_ITEMS, 0,  52);
        run_random_phase(RANDOM_ITEMS, 16, 16);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_locking();
        test_queue_full();
        test_backpressure();
        test_deep_nesting();
        test_random_traffic();

        // drain with the receiver always ready, then look for strays
        stall_pct = 0;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
